// ===== hdl/fpx_pkg.sv =====
// Shared types and constants for the frame parser with XOR check byte.
// Used by every module of the block; depends on nothing else.
package fpx_pkg;

    // Frame layout and limits.
    localparam int MAX_BODY       = 512;
    localparam int ID_LENGTH      = 20;
    localparam logic [7:0] PREFIX_A = 8'h53;
    localparam logic [7:0] PREFIX_B = 8'h4C;

    // Header positions: first byte in the check, and the two length bytes.
    localparam int CSUM_START     = ID_LENGTH + 3;
    localparam int LEN_HI_POS     = ID_LENGTH + 5;
    localparam int LEN_LO_POS     = ID_LENGTH + 6;
    localparam int FRAME_OVERHEAD = ID_LENGTH + 8;

    // Widths.
    localparam int POS_W      = $clog2(LEN_LO_POS + 1);
    localparam int BODY_CNT_W = $clog2(MAX_BODY);
    localparam int LEN_W      = 16;
    localparam int IDX_W      = 9;
    localparam int BLEN_W     = 9;
    localparam int PLEN_W     = 10;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_PENDING    = 3'd0,
        ST_OK         = 3'd1,
        ST_INVALID    = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_INCOMPLETE = 3'd4
    } status_t;

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_PRE0 = 7'b0000010,
        PH_PRE1 = 7'b0000100,
        PH_CMD  = 7'b0001000,
        PH_HDR  = 7'b0010000,
        PH_BODY = 7'b0100000,
        PH_CSUM = 7'b1000000
    } phase_t;

    // One input item.
    typedef struct packed {
        logic       first_byte;
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic                data_valid;
        logic [7:0]          data_byte;
        logic [IDX_W-1:0]    data_index;
        logic [7:0]          frame_cmd;
        logic [BLEN_W-1:0]   body_length;
        logic [PLEN_W-1:0]   parse_length;
    } result_t;

endpackage

// ===== hdl/fpx_in_stage.sv =====
// Input register of the frame parser: holds one accepted item.
// Depends on fpx_pkg.
module fpx_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpx_pkg::in_item_t s_item,
    output logic              item_valid,
    output fpx_pkg::in_item_t item,
    input  logic              item_take
);
    import fpx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage takes a new item whenever it is empty or its item moves on.
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/fpx_core.sv =====
// Parser state and the per-byte step logic of the frame parser.
// Depends on fpx_pkg.
module fpx_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  fpx_pkg::in_item_t item,
    output fpx_pkg::result_t  result
);
    import fpx_pkg::*;

    phase_t                phase_reg,   phase_next;
    logic [POS_W-1:0]      pos_reg,     pos_next;
    logic [7:0]            cmd_reg,     cmd_next;
    logic [LEN_W-1:0]      len_reg,     len_next;
    logic [BODY_CNT_W-1:0] cnt_reg,     cnt_next;
    logic [7:0]            xor_reg,     xor_next;

    phase_t                phase_cur;
    logic [POS_W-1:0]      pos_cur;
    logic [LEN_W-1:0]      len_cur;
    logic [BODY_CNT_W-1:0] cnt_cur;
    logic [7:0]            xor_cur;
    logic [7:0]            cmd_cur;
    logic [LEN_W-1:0]      len_full;
    logic [BODY_CNT_W:0]   cnt_inc;
    logic [31:0]           idx_wide;
    logic [31:0]           plen_wide;
    logic                  active;
    logic                  verdict;
    status_t               status;
    logic                  dvalid;
    logic [7:0]            dbyte;
    logic [IDX_W-1:0]      dindex;
    logic [PLEN_W-1:0]     plen;
    logic [7:0]            b;

    assign b        = item.byte_value;
    assign len_full = {len_reg[LEN_W-1:8], b};
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign idx_wide = 32'(cnt_reg);
    assign plen_wide = 32'(FRAME_OVERHEAD) + 32'(len_reg);

    // One byte of the parse: restart, phase step, position count and verdict.
    always_comb begin
        phase_cur = phase_reg;
        pos_cur   = pos_reg;
        cmd_cur   = cmd_reg;
        len_cur   = len_reg;
        cnt_cur   = cnt_reg;
        xor_cur   = xor_reg;
        status    = ST_PENDING;
        dvalid    = 1'b0;
        dbyte     = 8'd0;
        dindex    = '0;
        plen      = '0;
        verdict   = 1'b0;

        // A first byte restarts the frame and clears all captured values.
        if (item.first_byte) begin
            phase_cur = PH_PRE0;
            pos_cur   = '0;
            cmd_cur   = 8'd0;
            len_cur   = '0;
            cnt_cur   = '0;
            xor_cur   = 8'd0;
        end
        active     = (phase_cur != PH_IDLE);
        phase_next = phase_cur;
        pos_next   = pos_cur;
        cmd_next   = cmd_cur;
        len_next   = len_cur;
        cnt_next   = cnt_cur;
        xor_next   = xor_cur;

        unique case (phase_cur)
            PH_PRE0: begin
                if (b == PREFIX_A) begin
                    phase_next = PH_PRE1;
                end else begin
                    status  = ST_INVALID;
                    verdict = 1'b1;
                end
            end
            PH_PRE1: begin
                if (b == PREFIX_B) begin
                    phase_next = PH_CMD;
                end else begin
                    status  = ST_INVALID;
                    verdict = 1'b1;
                end
            end
            PH_CMD: begin
                cmd_next   = b;
                phase_next = PH_HDR;
            end
            PH_HDR: begin
                if (32'(pos_cur) >= 32'(CSUM_START)) begin
                    xor_next = xor_cur ^ b;
                end
                if (32'(pos_cur) == 32'(LEN_HI_POS)) begin
                    len_next = {b, 8'd0};
                end else if (32'(pos_cur) == 32'(LEN_LO_POS)) begin
                    len_next = len_full;
                    if (32'(len_full) >= 32'(MAX_BODY)) begin
                        status  = ST_OVERFLOW;
                        verdict = 1'b1;
                    end else if (len_full == '0) begin
                        phase_next = PH_CSUM;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                xor_next = xor_cur ^ b;
                dvalid   = 1'b1;
                dbyte    = b;
                dindex   = idx_wide[IDX_W-1:0];
                cnt_next = cnt_inc[BODY_CNT_W-1:0];
                if (32'(cnt_inc) >= 32'(len_cur)) begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM: begin
                verdict = 1'b1;
                if (xor_cur == b) begin
                    status = ST_OK;
                    plen   = plen_wide[PLEN_W-1:0];
                end else begin
                    status = ST_INVALID;
                end
            end
            default: begin
            end
        endcase

        // Position only matters up to the low length byte, so it saturates there.
        if (active && (32'(pos_cur) < 32'(LEN_LO_POS))) begin
            pos_next = pos_cur + 1'b1;
        end

        if (verdict) begin
            phase_next = PH_IDLE;
        end else if (active && item.last_byte) begin
            status     = ST_INCOMPLETE;
            phase_next = PH_IDLE;
        end
    end

    // Result fields for this item.
    always_comb begin
        result.status       = status;
        result.data_valid   = dvalid;
        result.data_byte    = dbyte;
        result.data_index   = dindex;
        result.frame_cmd    = cmd_next;
        result.body_length  = len_next[BLEN_W-1:0];
        result.parse_length = plen;
    end

    // Parser state, updated once per item that moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cmd_reg   <= 8'd0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            xor_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

// ===== hdl/fpx_out_stage.sv =====
// Result register of the frame parser: holds one finished result item.
// Depends on fpx_pkg.
module fpx_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  fpx_pkg::result_t res_in,
    output logic             m_valid,
    input  logic             m_ready,
    output fpx_pkg::result_t res_out
);
    import fpx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result loads when the register is empty or being emptied.
    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = (res_valid && res_ready) ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

// ===== hdl/frame_parser_xor_checksum_top.sv =====
// Byte-serial parser for a length-prefixed frame with an XOR check byte.
// Throughput: one item per cycle while m_ready is high; the input register,
// the one-step parse logic and the result register form a two-stage pipeline.
// Reset (synchronous, active low) empties both stages and returns the
// parser to idle with all captured values cleared.
module frame_parser_xor_checksum_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_first_byte,
    input  logic [7:0]                    s_byte_value,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic                          m_data_valid,
    output logic [7:0]                    m_data_byte,
    output logic [fpx_pkg::IDX_W-1:0]     m_data_index,
    output logic [7:0]                    m_frame_cmd,
    output logic [fpx_pkg::BLEN_W-1:0]    m_body_length,
    output logic [fpx_pkg::PLEN_W-1:0]    m_parse_length
);
    import fpx_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     res_ready;
    logic     step;
    result_t  res_core;
    result_t  res_out;

    assign s_item.first_byte = s_first_byte;
    assign s_item.byte_value = s_byte_value;
    assign s_item.last_byte  = s_last_byte;

    // An item is parsed as it moves from the input register to the result register.
    assign step = item_valid && res_ready;

    fpx_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step)
    );

    fpx_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (res_core)
    );

    fpx_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res_in    (res_core),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res_out   (res_out)
    );

    assign m_status       = res_out.status;
    assign m_data_valid   = res_out.data_valid;
    assign m_data_byte    = res_out.data_byte;
    assign m_data_index   = res_out.data_index;
    assign m_frame_cmd    = res_out.frame_cmd;
    assign m_body_length  = res_out.body_length;
    assign m_parse_length = res_out.parse_length;

`ifndef ASSERT_OFF
    // An empty result register never holds back the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

    // A body byte never carries a final verdict other than an early end.
    a_body_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_valid) |->
            (m_status == ST_PENDING || m_status == ST_INCOMPLETE))
        else $error("body item with a verdict status");

    // A parse length is reported only with an ok verdict.
    a_plen_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_parse_length != '0) |-> (m_status == ST_OK))
        else $error("parse length without an ok status");

    // An ok verdict reports the header and check byte size plus the captured body length.
    a_plen_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |->
            (m_parse_length == PLEN_W'(FRAME_OVERHEAD) + PLEN_W'(m_body_length)))
        else $error("parse length does not match the body length");
`endif

endmodule
